// ===== sv/weighted_three_queue_dispatcher_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the weighted three-queue dispatcher
// Clocked, reset-qualified forms of same-cycle and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_THREE_QUEUE_DISPATCHER_ASSERT_SVH
`define WEIGHTED_THREE_QUEUE_DISPATCHER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WTQD_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define WTQD_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/wtqd_pkg.sv =====
// ---------------------------------------------------------------------------
// Weighted three-queue dispatcher package
// Field widths, status and class codes, register indexes and command type.
// ---------------------------------------------------------------------------
package wtqd_pkg;

	localparam int TAG_W   = 16;
	localparam int STAMP_W = 16;
	localparam int ENTRY_W = TAG_W + STAMP_W;
	localparam int QUANT_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] STATUS_ADDED      = 2'd0;
	localparam logic [1:0] STATUS_DISPATCHED = 2'd1;
	localparam logic [1:0] STATUS_EMPTY      = 2'd2;
	localparam logic [1:0] STATUS_FULL       = 2'd3;

	localparam logic [1:0] CLS_UI    = 2'd0;
	localparam logic [1:0] CLS_FG    = 2'd1;
	localparam logic [1:0] CLS_OTHER = 2'd2;

	localparam logic FUNC_ADD      = 1'b0;
	localparam logic FUNC_DISPATCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_UI_QUANTUM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FG_QUANTUM = 1'b1;

	localparam logic [QUANT_W-1:0] UI_QUANTUM_RST = 4'd4;
	localparam logic [QUANT_W-1:0] FG_QUANTUM_RST = 4'd2;

	typedef struct packed {
		logic load;
		logic read;
		logic exec;
	} cmd_t;

endpackage

// ===== sv/wtqd_ctrl.sv =====
// ---------------------------------------------------------------------------
// Dispatcher controller
// Sequences accept, head read and execute; owns the output valid flag.
// ---------------------------------------------------------------------------
module wtqd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output wtqd_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.read = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/wtqd_datapath.sv =====
// ---------------------------------------------------------------------------
// Dispatcher datapath
// Three tag queues with arrival stamps, served counters, quanta and result.
// ---------------------------------------------------------------------------
module wtqd_datapath #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wtqd_pkg::cmd_t                     cmd,
	input  logic                               func,
	input  logic [1:0]                         req_class,
	input  logic [wtqd_pkg::TAG_W-1:0]         req_tag,
	input  logic                               cfg_we,
	input  logic [wtqd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wtqd_pkg::QUANT_W-1:0]       cfg_data,
	output logic [1:0]                         status,
	output logic [wtqd_pkg::TAG_W-1:0]         out_tag,
	output logic [1:0]                         out_class
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam int TW = wtqd_pkg::TAG_W;
	localparam int SW = wtqd_pkg::STAMP_W;
	localparam int QW = wtqd_pkg::QUANT_W;

	function automatic logic older(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW-1:0] diff;
		diff = a - b;
		return diff[SW-1];
	endfunction

	logic          func_q;
	logic [1:0]    cls_q;
	logic [TW-1:0] tag_q;

	logic [QW-1:0] ui_quantum_q;
	logic [QW-1:0] fg_quantum_q;
	logic [QW-1:0] ui_served_q;
	logic [QW-1:0] fg_served_q;
	logic [SW-1:0] arrival_q;

	logic [CW-1:0]                    cnt  [3];
	logic [wtqd_pkg::ENTRY_W-1:0]     head [3];
	logic [2:0]                       push_en;
	logic [2:0]                       pop_en;

	logic [1:0]    qsel;
	logic          full;
	logic [2:0]    nonempty;
	logic          ui_ok;
	logic          fg_ok;
	logic          found;
	logic [1:0]    pick;
	logic [SW-1:0] best;
	logic [1:0]    status_d;
	logic [TW-1:0] tag_d;
	logic [1:0]    class_d;
	logic [TW-1:0] pick_tag;

	generate
		for (genvar i = 0; i < 3; i++) begin : g_queue
			logic [wtqd_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];
			logic [PW-1:0]                wr_ptr_q;
			logic [PW-1:0]                rd_ptr_q;
			logic [CW-1:0]                cnt_q;
			logic [wtqd_pkg::ENTRY_W-1:0] head_q;

			always_ff @(posedge clk) begin
				if (push_en[i]) begin
					mem[wr_ptr_q] <= {arrival_q, tag_q};
				end
				if (cmd.read) begin
					head_q <= mem[rd_ptr_q];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					wr_ptr_q <= '0;
					rd_ptr_q <= '0;
					cnt_q    <= '0;
				end else begin
					if (push_en[i]) begin
						wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
						cnt_q    <= cnt_q + 1'b1;
					end
					if (pop_en[i]) begin
						rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
						cnt_q    <= cnt_q - 1'b1;
					end
				end
			end

			assign cnt[i]  = cnt_q;
			assign head[i] = head_q;
			assign nonempty[i] = (cnt_q != '0);
		end
	endgenerate

	always_comb begin
		case (cls_q)
			wtqd_pkg::CLS_UI: qsel = wtqd_pkg::CLS_UI;
			wtqd_pkg::CLS_FG: qsel = wtqd_pkg::CLS_FG;
			default:          qsel = wtqd_pkg::CLS_OTHER;
		endcase
	end

	always_comb begin
		case (qsel)
			wtqd_pkg::CLS_UI: full = (cnt[0] == CNT_FULL);
			wtqd_pkg::CLS_FG: full = (cnt[1] == CNT_FULL);
			default:          full = (cnt[2] == CNT_FULL);
		endcase
	end

	assign ui_ok = nonempty[0] && (ui_served_q < ui_quantum_q);
	assign fg_ok = nonempty[1] && (fg_served_q < fg_quantum_q);

	always_comb begin
		found = nonempty[2];
		pick  = wtqd_pkg::CLS_OTHER;
		best  = head[2][TW +: SW];
		if (nonempty[0] && (!found || older(head[0][TW +: SW], best))) begin
			found = 1'b1;
			pick  = wtqd_pkg::CLS_UI;
			best  = head[0][TW +: SW];
		end
		if (nonempty[1] && (!found || older(head[1][TW +: SW], best))) begin
			found = 1'b1;
			pick  = wtqd_pkg::CLS_FG;
		end
	end

	always_comb begin
		case (pick)
			wtqd_pkg::CLS_UI: pick_tag = head[0][TW-1:0];
			wtqd_pkg::CLS_FG: pick_tag = head[1][TW-1:0];
			default:          pick_tag = head[2][TW-1:0];
		endcase
	end

	always_comb begin
		push_en  = 3'b000;
		pop_en   = 3'b000;
		status_d = wtqd_pkg::STATUS_EMPTY;
		tag_d    = '0;
		class_d  = wtqd_pkg::CLS_UI;
		if (func_q == wtqd_pkg::FUNC_ADD) begin
			if (full) begin
				status_d = wtqd_pkg::STATUS_FULL;
			end else begin
				status_d = wtqd_pkg::STATUS_ADDED;
				push_en[qsel] = cmd.exec;
			end
		end else if (ui_ok) begin
			status_d  = wtqd_pkg::STATUS_DISPATCHED;
			tag_d     = head[0][TW-1:0];
			class_d   = wtqd_pkg::CLS_UI;
			pop_en[0] = cmd.exec;
		end else if (fg_ok) begin
			status_d  = wtqd_pkg::STATUS_DISPATCHED;
			tag_d     = head[1][TW-1:0];
			class_d   = wtqd_pkg::CLS_FG;
			pop_en[1] = cmd.exec;
		end else if (found) begin
			status_d     = wtqd_pkg::STATUS_DISPATCHED;
			tag_d        = pick_tag;
			class_d      = pick;
			pop_en[pick] = cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			cls_q  <= req_class;
			tag_q  <= req_tag;
		end
		if (cmd.exec) begin
			status    <= status_d;
			out_tag   <= tag_d;
			out_class <= class_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ui_quantum_q <= wtqd_pkg::UI_QUANTUM_RST;
			fg_quantum_q <= wtqd_pkg::FG_QUANTUM_RST;
			ui_served_q  <= '0;
			fg_served_q  <= '0;
			arrival_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == wtqd_pkg::CFG_UI_QUANTUM) begin
				ui_quantum_q <= cfg_data;
			end
			if (cfg_we && cfg_index == wtqd_pkg::CFG_FG_QUANTUM) begin
				fg_quantum_q <= cfg_data;
			end
			if (push_en != 3'b000) begin
				arrival_q <= arrival_q + 1'b1;
			end
			if (cmd.exec && func_q == wtqd_pkg::FUNC_DISPATCH) begin
				if (ui_ok) begin
					ui_served_q <= ui_served_q + 1'b1;
				end else if (fg_ok) begin
					fg_served_q <= fg_served_q + 1'b1;
				end else begin
					ui_served_q <= '0;
					fg_served_q <= '0;
				end
			end
		end
	end

endmodule

// ===== sv/weighted_three_queue_dispatcher.sv =====
// ---------------------------------------------------------------------------
// Weighted three-queue dispatcher
// Ui, foreground and other tag queues; quantum-weighted service with an
// oldest-head fallback.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  func, req_class, req_tag
//   out      output     out_valid/out_stall  status, out_tag, out_class
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// An item goes through accept, queue head read from the memories,
// then decide and write the result register.
// The next item is accepted while a result waits in the output register.
// A stalled result holds the execute step of the following item.
// Reset clears pointers, counts, served counters and the arrival stamp;
// queue memories need no clearing.
// ---------------------------------------------------------------------------
`include "weighted_three_queue_dispatcher_assert.svh"

module weighted_three_queue_dispatcher #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [1:0]                     req_class,
	input  logic [wtqd_pkg::TAG_W-1:0]     req_tag,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [wtqd_pkg::TAG_W-1:0]     out_tag,
	output logic [1:0]                     out_class,
	input  logic                           cfg_we,
	input  logic [wtqd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wtqd_pkg::QUANT_W-1:0]   cfg_data
);

	wtqd_pkg::cmd_t cmd;

	wtqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	wtqd_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (func),
		.req_class (req_class),
		.req_tag   (req_tag),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.out_tag   (out_tag),
		.out_class (out_class)
	);

	`WTQD_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall, "accepted item did not leave idle")
	`WTQD_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared without an item in work")
	`WTQD_ASSERT_IMP(a_zero_fields, clk, arst_n, out_valid && status != wtqd_pkg::STATUS_DISPATCHED, out_tag == '0 && out_class == wtqd_pkg::CLS_UI, "non-dispatch result carries tag or class")
	`WTQD_ASSERT_IMP(a_class_range, clk, arst_n, out_valid && status == wtqd_pkg::STATUS_DISPATCHED, out_class != 2'd3, "dispatched from a nonexistent queue")

endmodule
